@@ design/sfr_pkg.sv @@
package sfr_pkg;

    localparam int MAX_FRAGMENTS    = 64;
    localparam int FRAGMENT_BYTES   = 1024;
    localparam int MAX_RECORD_BYTES = 65536;

    // bitmap index width, at least one bit
    localparam int IDX_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_WORLD_ID = 2'd0;
    localparam logic [1:0] CFG_ASSET_ID = 2'd1;
    localparam logic [1:0] CFG_MAX_BYTES = 2'd2;

    // fragment status codes
    localparam logic [1:0] ST_PENDING   = 2'd0;
    localparam logic [1:0] ST_COMPLETE  = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_DUPLICATE = 2'd3;

    typedef struct packed {
        logic [63:0] scene_identity;
        logic [63:0] asset_identity;
        logic [16:0] max_record_bytes;
    } sfr_cfg_t;

    typedef struct packed {
        logic             first;
        logic             last;
        logic             hdr_ok;
        logic [63:0]      transfer_tag;
        logic [63:0]      region_key;
        logic [63:0]      region_revision;
        logic [31:0]      region_generation;
        logic [16:0]      record_bytes;
        logic [6:0]       fragment_total;
        logic [IDX_W-1:0] frag_index;
        logic [10:0]      payload_size;
        logic [15:0]      address;
        logic [7:0]       payload_byte;
    } sfr_entry_t;

endpackage

@@ design/sfr_if.sv @@
interface sfr_rx_if;
    logic        valid;
    logic        ready;
    logic [63:0] scene_identity;
    logic [63:0] asset_identity;
    logic [63:0] transfer_tag;
    logic [63:0] region_key;
    logic [63:0] region_revision;
    logic [31:0] region_generation;
    logic [16:0] record_bytes;
    logic [6:0]  fragment_total;
    logic [6:0]  fragment_number;
    logic [10:0] payload_size;
    logic [7:0]  payload_byte;

    modport source (
        output valid, scene_identity, asset_identity, transfer_tag, region_key,
               region_revision, region_generation, record_bytes, fragment_total,
               fragment_number, payload_size, payload_byte,
        input  ready
    );
    modport sink (
        input  valid, scene_identity, asset_identity, transfer_tag, region_key,
               region_revision, region_generation, record_bytes, fragment_total,
               fragment_number, payload_size, payload_byte,
        output ready
    );
endinterface

interface sfr_tx_if;
    logic        valid;
    logic        ready;
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        restart;
    logic        fragment_end;
    logic [1:0]  status;

    modport source (
        output valid, write_enable, write_address, write_data, restart,
               fragment_end, status,
        input  ready
    );
    modport sink (
        input  valid, write_enable, write_address, write_data, restart,
               fragment_end, status,
        output ready
    );
endinterface

@@ design/snapshot_fragment_reassembly.sv @@
// a payload byte is written into the queue, then registered in the back end's output register
// throughput: one byte per cycle while the output is not stalled; the back end updates the bitmap as it takes each byte
// the two-entry queue between front and back holds bytes while the output is stalled
// reset: asynchronous active low; no transfer open, bitmap cleared,
// max_record_bytes at its largest value; no clearing pass is needed
module snapshot_fragment_reassembly (
    input  logic        clk,
    input  logic        rst_n,
    sfr_rx_if.sink      rx,
    sfr_tx_if.source    tx,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import sfr_pkg::*;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    logic [63:0] world_id_reg, world_id_next;
    logic [63:0] asset_id_reg, asset_id_next;
    logic [16:0] max_bytes_reg, max_bytes_next;
    sfr_cfg_t    cfg;

    // front to queue
    logic       push_valid;
    logic       push_ready;
    sfr_entry_t push_entry;

    // queue to back
    logic       pop_valid;
    logic       pop_ready;
    sfr_entry_t pop_entry;

    always_comb
    begin
        world_id_next  = world_id_reg;
        asset_id_next  = asset_id_reg;
        max_bytes_next = max_bytes_reg;
        if (cfg_we)
        begin
            // indexes past the register list are dropped
            case (cfg_index)
                CFG_WORLD_ID:  world_id_next  = cfg_data;
                CFG_ASSET_ID:  asset_id_next  = cfg_data;
                CFG_MAX_BYTES: max_bytes_next = cfg_data[16:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_id_reg  <= '0;
            asset_id_reg  <= '0;
            max_bytes_reg <= 17'(MAX_RECORD_BYTES);
        end
        else
        begin
            world_id_reg  <= world_id_next;
            asset_id_reg  <= asset_id_next;
            max_bytes_reg <= max_bytes_next;
        end
    end

    // identities first, record size bound last
    assign cfg = {world_id_reg, asset_id_reg, max_bytes_reg};

    // front: tracks byte position, checks the header, forms the write address
    sfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    // short queue decouples front and back stalls
    sfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    // back: transfer bookkeeping, bitmap, status and output register
    sfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop_ready (pop_ready),
        .tx        (tx)
    );

endmodule

@@ design/sfr_front.sv @@
module sfr_front (
    input  logic                clk,
    input  logic                rst_n,
    sfr_rx_if.sink              rx,
    input  sfr_pkg::sfr_cfg_t   cfg,
    output logic                push_valid,
    output sfr_pkg::sfr_entry_t push_entry,
    input  logic                push_ready
);
    import sfr_pkg::*;

    logic [10:0] pos_reg, pos_next;
    logic [10:0] len_reg, len_next;
    logic [15:0] base_reg, base_next;

    logic        first;
    logic        last;
    logic        hdr_ok;
    logic [10:0] len_cur;
    logic [15:0] base_cur;
    logic [17:0] offset;
    logic [18:0] frag_end_pos;
    logic        accept;

    assign rx.ready   = push_ready;
    assign push_valid = rx.valid;
    assign accept     = rx.valid && push_ready;

    assign first  = (pos_reg == 11'd0);
    assign offset = 18'(rx.fragment_number) * 18'(FRAGMENT_BYTES);
    assign frag_end_pos = 19'(offset) + 19'(rx.payload_size);

    always_comb
    begin
        hdr_ok = 1'b1;
        if (rx.scene_identity != cfg.scene_identity
            || rx.asset_identity != cfg.asset_identity)
            hdr_ok = 1'b0;
        if (rx.transfer_tag == 64'd0)
            hdr_ok = 1'b0;
        if (rx.fragment_total == 7'd0
            || 8'(rx.fragment_total) > 8'(MAX_FRAGMENTS)
            || rx.fragment_number >= rx.fragment_total)
            hdr_ok = 1'b0;
        if (rx.record_bytes == 17'd0 || rx.record_bytes > cfg.max_record_bytes
            || 18'(rx.record_bytes) > 18'(MAX_RECORD_BYTES))
            hdr_ok = 1'b0;
        if (rx.payload_size == 11'd0
            || 12'(rx.payload_size) > 12'(FRAGMENT_BYTES))
            hdr_ok = 1'b0;
        // fragment must fit inside the record
        if (offset > 18'(rx.record_bytes) || frag_end_pos > 19'(rx.record_bytes))
            hdr_ok = 1'b0;
    end

    assign len_cur  = first ? ((rx.payload_size == 11'd0) ? 11'd1 : rx.payload_size)
                            : len_reg;
    assign base_cur = first ? offset[15:0] : base_reg;
    assign last     = (12'(pos_reg) + 12'd1 >= 12'(len_cur));

    always_comb
    begin
        pos_next  = pos_reg;
        len_next  = len_reg;
        base_next = base_reg;
        if (accept)
        begin
            len_next  = len_cur;
            base_next = base_cur;
            pos_next  = last ? 11'd0 : pos_reg + 11'd1;
        end
    end

    always_comb
    begin
        push_entry                   = '0;
        push_entry.first             = first;
        push_entry.last              = last;
        push_entry.hdr_ok            = hdr_ok;
        push_entry.transfer_tag      = rx.transfer_tag;
        push_entry.region_key        = rx.region_key;
        push_entry.region_revision   = rx.region_revision;
        push_entry.region_generation = rx.region_generation;
        push_entry.record_bytes      = rx.record_bytes;
        push_entry.fragment_total    = rx.fragment_total;
        push_entry.frag_index        = rx.fragment_number[IDX_W-1:0];
        push_entry.payload_size      = rx.payload_size;
        push_entry.address           = base_cur + 16'(pos_reg);
        push_entry.payload_byte      = rx.payload_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            len_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            base_reg <= base_next;
        end
    end

endmodule

@@ design/sfr_queue.sv @@
module sfr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  sfr_pkg::sfr_entry_t push_entry,
    output logic                push_ready,
    output logic                pop_valid,
    output sfr_pkg::sfr_entry_t pop_entry,
    input  logic                pop_ready
);
    import sfr_pkg::*;

    sfr_entry_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/sfr_back.sv @@
module sfr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    input  sfr_pkg::sfr_entry_t pop_entry,
    output logic                pop_ready,
    sfr_tx_if.source            tx
);
    import sfr_pkg::*;

    // open transfer state
    logic [63:0]              tag_reg, tag_next;
    logic [63:0]              region_reg, region_next;
    logic [63:0]              revision_reg, revision_next;
    logic [31:0]              generation_reg, generation_next;
    logic [16:0]              total_bytes_reg, total_bytes_next;
    logic [6:0]               frag_total_reg, frag_total_next;
    logic [6:0]               frags_seen_reg, frags_seen_next;
    logic [16:0]              bytes_seen_reg, bytes_seen_next;
    logic [MAX_FRAGMENTS-1:0] seen_map_reg, seen_map_next;
    logic                     accepted_reg, accepted_next;
    logic [1:0]               verdict_reg, verdict_next;

    // output stage
    logic        out_valid_reg, out_valid_next;
    logic        out_we_reg, out_we_next;
    logic [15:0] out_addr_reg, out_addr_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic        out_restart_reg, out_restart_next;
    logic        out_fend_reg, out_fend_next;
    logic [1:0]  out_status_reg, out_status_next;

    logic fire;
    logic same_hdr;
    logic opens;

    assign pop_ready = !out_valid_reg || tx.ready;
    assign fire      = pop_valid && pop_ready;

    assign same_hdr = (tag_reg != 64'd0)
                   && tag_reg == pop_entry.transfer_tag
                   && region_reg == pop_entry.region_key
                   && revision_reg == pop_entry.region_revision
                   && generation_reg == pop_entry.region_generation
                   && total_bytes_reg == pop_entry.record_bytes
                   && frag_total_reg == pop_entry.fragment_total;

    assign opens = pop_entry.first && pop_entry.hdr_ok && !same_hdr;

    always_comb
    begin
        tag_next         = tag_reg;
        region_next      = region_reg;
        revision_next    = revision_reg;
        generation_next  = generation_reg;
        total_bytes_next = total_bytes_reg;
        frag_total_next  = frag_total_reg;
        frags_seen_next  = frags_seen_reg;
        bytes_seen_next  = bytes_seen_reg;
        seen_map_next    = seen_map_reg;
        accepted_next    = accepted_reg;
        verdict_next     = verdict_reg;

        out_valid_next   = out_valid_reg && !tx.ready;
        out_we_next      = out_we_reg;
        out_addr_next    = out_addr_reg;
        out_data_next    = out_data_reg;
        out_restart_next = out_restart_reg;
        out_fend_next    = out_fend_reg;
        out_status_next  = out_status_reg;

        if (fire)
        begin
            out_valid_next   = 1'b1;
            out_restart_next = opens && (tag_reg != 64'd0);

            if (pop_entry.first)
            begin
                accepted_next = 1'b0;
                verdict_next  = ST_INVALID;
                if (pop_entry.hdr_ok)
                begin
                    // new header replaces whatever was open
                    if (opens)
                    begin
                        tag_next         = pop_entry.transfer_tag;
                        region_next      = pop_entry.region_key;
                        revision_next    = pop_entry.region_revision;
                        generation_next  = pop_entry.region_generation;
                        total_bytes_next = pop_entry.record_bytes;
                        frag_total_next  = pop_entry.fragment_total;
                        frags_seen_next  = '0;
                        bytes_seen_next  = '0;
                        seen_map_next    = '0;
                    end
                    if (seen_map_next[pop_entry.frag_index])
                    begin
                        verdict_next = ST_DUPLICATE;
                    end
                    else
                    begin
                        seen_map_next[pop_entry.frag_index] = 1'b1;
                        frags_seen_next = frags_seen_next + 7'd1;
                        bytes_seen_next = bytes_seen_next + 17'(pop_entry.payload_size);
                        accepted_next   = 1'b1;
                        verdict_next    = ST_PENDING;
                    end
                end
            end

            out_we_next   = accepted_next;
            out_addr_next = accepted_next ? pop_entry.address : 16'd0;
            out_data_next = accepted_next ? pop_entry.payload_byte : 8'd0;
            out_fend_next   = pop_entry.last;
            out_status_next = ST_PENDING;

            if (pop_entry.last)
            begin
                out_status_next = verdict_next;
                if (accepted_next && frags_seen_next >= frag_total_next
                    && bytes_seen_next == total_bytes_next)
                begin
                    out_status_next  = ST_COMPLETE;
                    tag_next         = '0;
                    region_next      = '0;
                    revision_next    = '0;
                    generation_next  = '0;
                    total_bytes_next = '0;
                    frag_total_next  = '0;
                    frags_seen_next  = '0;
                    bytes_seen_next  = '0;
                    seen_map_next    = '0;
                end
                accepted_next = 1'b0;
                verdict_next  = ST_PENDING;
            end
        end
    end

    assign tx.valid         = out_valid_reg;
    assign tx.write_enable  = out_we_reg;
    assign tx.write_address = out_addr_reg;
    assign tx.write_data    = out_data_reg;
    assign tx.restart       = out_restart_reg;
    assign tx.fragment_end  = out_fend_reg;
    assign tx.status        = out_status_reg;

    always_ff @(posedge clk)
    begin
        out_we_reg      <= out_we_next;
        out_addr_reg    <= out_addr_next;
        out_data_reg    <= out_data_next;
        out_restart_reg <= out_restart_next;
        out_fend_reg    <= out_fend_next;
        out_status_reg  <= out_status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg         <= '0;
            region_reg      <= '0;
            revision_reg    <= '0;
            generation_reg  <= '0;
            total_bytes_reg <= '0;
            frag_total_reg  <= '0;
            frags_seen_reg  <= '0;
            bytes_seen_reg  <= '0;
            seen_map_reg    <= '0;
            accepted_reg    <= 1'b0;
            verdict_reg     <= ST_PENDING;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            tag_reg         <= tag_next;
            region_reg      <= region_next;
            revision_reg    <= revision_next;
            generation_reg  <= generation_next;
            total_bytes_reg <= total_bytes_next;
            frag_total_reg  <= frag_total_next;
            frags_seen_reg  <= frags_seen_next;
            bytes_seen_reg  <= bytes_seen_next;
            seen_map_reg    <= seen_map_next;
            accepted_reg    <= accepted_next;
            verdict_reg     <= verdict_next;
            out_valid_reg   <= out_valid_next;
        end
    end

endmodule

@@ sim/tb_snapshot_fragment_reassembly.sv @@
`timescale 1ns / 1ps

module tb_snapshot_fragment_reassembly;
    import sfr_pkg::*;

    // one payload byte with its fragment header, as offered on the input channel
    typedef struct packed {
        logic [63:0] scene_identity;
        logic [63:0] asset_identity;
        logic [63:0] transfer_tag;
        logic [63:0] region_key;
        logic [63:0] region_revision;
        logic [31:0] region_generation;
        logic [16:0] record_bytes;
        logic [6:0]  fragment_total;
        logic [6:0]  fragment_number;
        logic [10:0] payload_size;
        logic [7:0]  payload_byte;
    } frag_item_t;

    // one buffer write report from the output channel
    typedef struct packed {
        logic        we;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        restart;
        logic        fend;
        logic [1:0]  status;
    } store_write_t;

    // directed stimulus row: typed rows carry their own expected write
    typedef struct {
        frag_item_t   item;
        bit           typed;
        store_write_t want;
    } stim_row_t;

    // the usual answer to a one-byte fragment with a bad header
    localparam store_write_t BAD_HDR = '{we: 1'b0, addr: 16'd0, data: 8'd0, restart: 1'b0,
                                         fend: 1'b1, status: ST_INVALID};
    localparam store_write_t QUIET   = '{we: 1'b0, addr: 16'd0, data: 8'd0, restart: 1'b0,
                                         fend: 1'b0, status: ST_PENDING};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    sfr_rx_if rx_if ();
    sfr_tx_if tx_if ();

    snapshot_fragment_reassembly dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_if),
        .tx        (tx_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: configuration copy
    // ------------------------------------------------------------------
    logic [63:0] want_world;
    logic [63:0] want_asset;
    logic [16:0] rec_limit;

    // open transfer bookkeeping
    logic [63:0] open_tag;
    logic [63:0] open_key;
    logic [63:0] open_rev;
    logic [31:0] open_gen;
    logic [16:0] open_rec;
    logic [6:0]  open_tot;
    logic [6:0]  frag_cnt;
    logic [16:0] byte_cnt;
    bit          frag_seen [MAX_FRAGMENTS];

    // per-fragment tracking, latched on the first byte
    logic [10:0] pos;
    logic        pass_frag;
    logic [1:0]  verdict;
    logic [15:0] base_addr;
    logic [10:0] span;

    // expected buffer writes, oldest first
    store_write_t pending_writes [$];
    stim_row_t    stim_table [$];
    frag_item_t   last_hdr;

    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    bit          hold_req;
    int          mismatch_count;
    int unsigned items_sent;

    // drop the open transfer and its fragment bitmap
    task automatic clear_open();
        open_tag = '0;
        open_key = '0;
        open_rev = '0;
        open_gen = '0;
        open_rec = '0;
        open_tot = '0;
        frag_cnt = '0;
        byte_cnt = '0;
        frag_seen = '{default: 1'b0};
    endtask

    // header checks made on the first byte of a fragment
    function automatic bit header_ok(input frag_item_t it);
        int unsigned rec;
        int unsigned tot;
        int unsigned num;
        int unsigned psz;
        int unsigned off;
        rec = it.record_bytes;
        tot = it.fragment_total;
        num = it.fragment_number;
        psz = it.payload_size;
        off = num * FRAGMENT_BYTES;
        if (it.scene_identity != want_world || it.asset_identity != want_asset)
            return 1'b0;
        if (it.transfer_tag == '0)
            return 1'b0;
        if (tot == 0 || tot > MAX_FRAGMENTS || num >= tot)
            return 1'b0;
        if (rec == 0 || rec > rec_limit || rec > MAX_RECORD_BYTES)
            return 1'b0;
        if (psz == 0 || psz > FRAGMENT_BYTES)
            return 1'b0;
        if (off > rec || psz > rec - off)
            return 1'b0;
        return 1'b1;
    endfunction

    // advance the reassembly state by one byte and give the write it causes
    task automatic reasm_predict(input frag_item_t it, output store_write_t r);
        int unsigned num;
        bit          same;
        r = QUIET;
        if (pos == 11'd0)
        begin
            num = it.fragment_number;
            span = (it.payload_size == 11'd0) ? 11'd1 : it.payload_size;
            base_addr = 16'(num * FRAGMENT_BYTES);
            pass_frag = 1'b0;
            if (!header_ok(it))
                verdict = ST_INVALID;
            else
            begin
                same = open_tag == it.transfer_tag && open_key == it.region_key &&
                       open_rev == it.region_revision && open_gen == it.region_generation &&
                       open_rec == it.record_bytes && open_tot == it.fragment_total;
                // a differing header replaces whatever is open
                if (open_tag == '0 || !same)
                begin
                    r.restart = (open_tag != '0);
                    clear_open();
                    open_tag = it.transfer_tag;
                    open_key = it.region_key;
                    open_rev = it.region_revision;
                    open_gen = it.region_generation;
                    open_rec = it.record_bytes;
                    open_tot = it.fragment_total;
                end
                if (frag_seen[num])
                    verdict = ST_DUPLICATE;
                else
                begin
                    frag_seen[num] = 1'b1;
                    frag_cnt = frag_cnt + 7'd1;
                    byte_cnt = byte_cnt + it.payload_size;
                    pass_frag = 1'b1;
                    verdict = ST_PENDING;
                end
            end
        end
        if (pass_frag)
        begin
            r.we = 1'b1;
            r.addr = base_addr + 16'(pos);
            r.data = it.payload_byte;
        end
        if (32'(pos) + 1 >= 32'(span))
        begin
            r.fend = 1'b1;
            r.status = verdict;
            // completion needs every fragment and the exact byte total
            if (pass_frag && frag_cnt >= open_tot && byte_cnt == open_rec)
            begin
                r.status = ST_COMPLETE;
                clear_open();
            end
            pos = 11'd0;
            pass_frag = 1'b0;
            verdict = ST_PENDING;
        end
        else
            pos = pos + 11'd1;
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic frag_item_t random_item();
        frag_item_t it;
        it.scene_identity    = {$urandom, $urandom};
        it.asset_identity    = {$urandom, $urandom};
        it.transfer_tag      = {$urandom, $urandom};
        it.region_key        = {$urandom, $urandom};
        it.region_revision   = {$urandom, $urandom};
        it.region_generation = $urandom;
        it.record_bytes      = 17'($urandom);
        it.fragment_total    = 7'($urandom);
        it.fragment_number   = 7'($urandom);
        it.payload_size      = 11'($urandom);
        it.payload_byte      = 8'($urandom);
        return it;
    endfunction

    // directed header: world all ones, asset zero, region fields at extremes
    function automatic frag_item_t dir_item(input logic [63:0] tag, input logic [16:0] rec,
                                            input logic [6:0] tot, input logic [6:0] num,
                                            input logic [10:0] psz, input logic [7:0] b);
        frag_item_t it;
        it.scene_identity    = '1;
        it.asset_identity    = '0;
        it.transfer_tag      = tag;
        it.region_key        = '1;
        it.region_revision   = '0;
        it.region_generation = '1;
        it.record_bytes      = rec;
        it.fragment_total    = tot;
        it.fragment_number   = num;
        it.payload_size      = psz;
        it.payload_byte      = b;
        return it;
    endfunction

    function automatic void add_stim(input frag_item_t it, input bit typed,
                                     input store_write_t want);
        stim_table.push_back('{it, typed, want});
    endfunction

    task automatic present(input frag_item_t it);
        rx_if.scene_identity    <= it.scene_identity;
        rx_if.asset_identity    <= it.asset_identity;
        rx_if.transfer_tag      <= it.transfer_tag;
        rx_if.region_key        <= it.region_key;
        rx_if.region_revision   <= it.region_revision;
        rx_if.region_generation <= it.region_generation;
        rx_if.record_bytes      <= it.record_bytes;
        rx_if.fragment_total    <= it.fragment_total;
        rx_if.fragment_number   <= it.fragment_number;
        rx_if.payload_size      <= it.payload_size;
        rx_if.payload_byte      <= it.payload_byte;
    endtask

    // offer one byte, wait for the transaction, then record what it must produce
    task automatic drive_item(input frag_item_t it, input bit typed, input store_write_t want);
        store_write_t pred;
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid <= 1'b1;
        present(it);
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        reasm_predict(it, pred);
        pending_writes.push_back(typed ? want : pred);
        items_sent++;
    endtask

    // a whole fragment; later bytes may carry a scrambled header, which is ignored
    task automatic send_fragment(input frag_item_t hdr, input bit scramble);
        int unsigned n;
        frag_item_t  it;
        n = (hdr.payload_size == 11'd0) ? 1 : hdr.payload_size;
        for (int unsigned i = 0; i < n; i++)
        begin
            it = (i != 0 && scramble) ? random_item() : hdr;
            it.payload_byte = 8'($urandom);
            drive_item(it, 1'b0, QUIET);
        end
    endtask

    // mostly well-formed transfer with random content, sometimes broken on purpose
    task automatic gen_transfer();
        frag_item_t  hdr;
        frag_item_t  frag;
        int unsigned tot;
        int unsigned rec;
        int unsigned hi;
        int unsigned nfrag;
        int unsigned num;
        int unsigned room;
        int unsigned k;
        int unsigned j;
        int unsigned t;
        int unsigned flaw;
        int unsigned order [MAX_FRAGMENTS];
        bit          twice;
        if (last_hdr.transfer_tag != '0 && $urandom_range(3) == 0)
        begin
            // keep feeding the same transfer
            hdr = last_hdr;
            hdr.scene_identity = want_world;
            hdr.asset_identity = want_asset;
        end
        else
        begin
            hdr = random_item();
            hdr.scene_identity = want_world;
            hdr.asset_identity = want_asset;
            if (hdr.transfer_tag == '0)
                hdr.transfer_tag = 64'd1;
            if ($urandom_range(1))
                tot = 1;
            else if ($urandom_range(7) != 0)
                tot = $urandom_range(4, 2);
            else
                tot = $urandom_range(MAX_FRAGMENTS, 5);
            if (tot == 1)
            begin
                hi = 6;
                if (rec_limit != '0 && rec_limit < hi)
                    hi = rec_limit;
                rec = $urandom_range(hi, 1);
            end
            else
                rec = (tot - 1) * FRAGMENT_BYTES + $urandom_range(6, 1);
            hdr.fragment_total = 7'(tot);
            hdr.record_bytes = 17'(rec);
        end
        last_hdr = hdr;
        tot = hdr.fragment_total;
        rec = hdr.record_bytes;
        nfrag = (tot < 5) ? tot : $urandom_range(5, 2);
        // random arrival order of fragment indexes
        for (k = 0; k < tot; k++)
            order[k] = k;
        for (k = tot - 1; k > 0; k--)
        begin
            j = $urandom_range(k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        for (k = 0; k < nfrag; k++)
        begin
            num = order[k];
            room = rec - num * FRAGMENT_BYTES;
            frag = hdr;
            frag.fragment_number = 7'(num);
            if (tot == 1)
                frag.payload_size = 11'(rec);
            else
                frag.payload_size = 11'($urandom_range((room < 4) ? room : 4, 1));
            twice = 1'b0;
            flaw = $urandom_range(15);
            case (flaw)
                0: frag.scene_identity[$urandom_range(63)] ^= 1'b1;
                1: frag.transfer_tag = '0;
                2: frag.payload_size = '0;
                3: frag.fragment_number = 7'($urandom_range(127, tot));
                4: frag.region_revision = {$urandom, $urandom};
                5: twice = 1'b1;
                default: ;
            endcase
            send_fragment(frag, $urandom_range(7) == 0);
            if (twice)
                send_fragment(frag, 1'b0);
        end
    endtask

    // three register writes back to back, predictor follows
    task automatic cfg_set(input logic [63:0] world, input logic [63:0] asset,
                           input logic [16:0] max_bytes);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WORLD_ID;
        cfg_data  <= world;
        @(posedge clk);
        cfg_index <= CFG_ASSET_ID;
        cfg_data  <= asset;
        @(posedge clk);
        cfg_index <= CFG_MAX_BYTES;
        cfg_data  <= 64'(max_bytes);
        @(posedge clk);
        cfg_we    <= 1'b0;
        want_world = world;
        want_asset = asset;
        rec_limit  = max_bytes;
    endtask

    // let every expected write come out, then let the pipeline settle
    task automatic drain();
        rx_if.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // output side: compare, then decide ready for the next edge
    // ------------------------------------------------------------------
    task automatic cmp_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            mismatch_count++;
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want_v, got_v);
        end
    endtask

    task automatic check_write();
        store_write_t want;
        store_write_t got;
        got = {tx_if.write_enable, tx_if.write_address, tx_if.write_data, tx_if.restart,
               tx_if.fragment_end, tx_if.status};
        if (pending_writes.size() == 0)
        begin
            mismatch_count++;
            $display("%0t ns: unexpected write, expected none actual %p", $time, got);
        end
        else
        begin
            want = pending_writes.pop_front();
            cmp_field("write_enable", 16'(want.we), 16'(got.we));
            cmp_field("write_address", want.addr, got.addr);
            cmp_field("write_data", 16'(want.data), 16'(got.data));
            cmp_field("restart", 16'(want.restart), 16'(got.restart));
            cmp_field("fragment_end", 16'(want.fend), 16'(got.fend));
            cmp_field("status", 16'(want.status), 16'(got.status));
        end
    endtask

    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        tx_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && tx_if.valid && tx_if.ready)
                check_write();
            // long hold-off so the block fills and backs up its input
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                tx_if.ready <= 1'b0;
            end
            else
                tx_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        frag_item_t  frag;
        frag_item_t  odd;
        int unsigned goal;
        int unsigned rec;

        rst_n          = 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_WORLD_ID;
        cfg_data      <= '0;
        rx_if.valid   <= 1'b0;
        present('0);
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        hold_req       = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        last_hdr       = '0;

        // predictor at reset
        want_world = '0;
        want_asset = '0;
        rec_limit  = 17'(MAX_RECORD_BYTES);
        clear_open();
        pos       = '0;
        pass_frag = 1'b0;
        verdict   = ST_PENDING;
        base_addr = '0;
        span      = '0;

        // directed table
        add_stim(dir_item(64'd1, 17'd2, 7'd1, 7'd0, 11'd0, 8'h00), 1'b1, BAD_HDR);  // empty fragment
        add_stim(dir_item(64'd0, 17'd2, 7'd1, 7'd0, 11'd1, 8'hFF), 1'b1, BAD_HDR);  // zero tag
        odd = dir_item(64'd1, 17'd2, 7'd1, 7'd0, 11'd1, 8'h5A);
        odd.scene_identity = '0;                                                    // wrong world
        add_stim(odd, 1'b1, BAD_HDR);
        odd = dir_item(64'd1, 17'd2, 7'd1, 7'd0, 11'd1, 8'h5A);
        odd.asset_identity = 64'd1;                                                 // wrong asset
        add_stim(odd, 1'b1, BAD_HDR);
        add_stim(dir_item(64'd1, 17'd2, 7'd0, 7'd0, 11'd1, 8'h01), 1'b1, BAD_HDR);  // no fragments
        add_stim(dir_item(64'd1, 17'h10000, 7'd65, 7'd0, 11'd1, 8'h02), 1'b1, BAD_HDR);
        add_stim(dir_item(64'd1, 17'h10000, 7'h7F, 7'h7F, 11'd1, 8'h03), 1'b1, BAD_HDR);
        add_stim(dir_item(64'd1, 17'd2, 7'd1, 7'd1, 11'd1, 8'h04), 1'b1, BAD_HDR);  // index past total
        add_stim(dir_item(64'd1, 17'd0, 7'd1, 7'd0, 11'd1, 8'h05), 1'b1, BAD_HDR);  // empty record
        add_stim(dir_item(64'd1, 17'h1FFFF, 7'd1, 7'd0, 11'd1, 8'h06), 1'b1, BAD_HDR);
        add_stim(dir_item(64'd1, 17'd1024, 7'd2, 7'd1, 11'd1, 8'h07), 1'b1, BAD_HDR); // no room
        // fragment larger than the record: rejected but still spans its bytes
        add_stim(dir_item(64'd1, 17'd1, 7'd1, 7'd0, 11'd2, 8'h08), 1'b1, QUIET);
        add_stim(dir_item(64'd1, 17'd1, 7'd1, 7'd0, 11'd2, 8'h09), 1'b1, BAD_HDR);
        // single-fragment record, nothing open before it
        add_stim(dir_item(64'd5, 17'd2, 7'd1, 7'd0, 11'd2, 8'h00), 1'b1,
                 '{we: 1'b1, addr: 16'd0, data: 8'h00, restart: 1'b0, fend: 1'b0,
                   status: ST_PENDING});
        add_stim(dir_item(64'd5, 17'd2, 7'd1, 7'd0, 11'd2, 8'hFF), 1'b1,
                 '{we: 1'b1, addr: 16'd1, data: 8'hFF, restart: 1'b0, fend: 1'b1,
                   status: ST_COMPLETE});
        // last index of the largest record, its duplicate, then index zero
        add_stim(dir_item('1, 17'h10000, 7'd64, 7'd63, 11'd1, 8'hA5), 1'b0, QUIET);
        add_stim(dir_item('1, 17'h10000, 7'd64, 7'd63, 11'd1, 8'h5A), 1'b0, QUIET);
        add_stim(dir_item('1, 17'h10000, 7'd64, 7'd0, 11'd1, 8'h3C), 1'b0, QUIET);
        // new tag restarts; all fragments in but byte total short, so it stays open
        add_stim(dir_item(64'd2, 17'd1025, 7'd2, 7'd1, 11'd1, 8'hC3), 1'b0, QUIET);
        add_stim(dir_item(64'd2, 17'd1025, 7'd2, 7'd0, 11'd1, 8'h96), 1'b0, QUIET);
        add_stim(dir_item(64'd2, 17'd1025, 7'd2, 7'd1, 11'd1, 8'h69), 1'b0, QUIET);
        // header changing inside a fragment: only the first byte counts
        add_stim(dir_item(64'd3, 17'd3, 7'd1, 7'd0, 11'd3, 8'h11), 1'b0, QUIET);
        odd = dir_item(64'd0, 17'd0, 7'd0, 7'd0, 11'd0, 8'h22);
        odd.scene_identity = '0;
        add_stim(odd, 1'b0, QUIET);
        add_stim(dir_item('1, 17'h1FFFF, 7'h7F, 7'h7F, 11'h7FF, 8'h33), 1'b0, QUIET);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_set('1, '0, 17'(MAX_RECORD_BYTES));
        foreach (stim_table[i])
            drive_item(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
        drain();

        // random phases, each with its own register setting and idling mix
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin
                    cfg_set({$urandom, $urandom}, {$urandom, $urandom}, 17'(MAX_RECORD_BYTES));
                    src_idle_pct = 0;  snk_stall_pct = 0;
                end
                1: begin
                    cfg_set('0, '1, 17'($urandom_range(4096, 16)));
                    src_idle_pct = 61; snk_stall_pct = 0;
                end
                2: begin
                    cfg_set('1, '0, 17'd1);
                    src_idle_pct = 0;  snk_stall_pct = 61;
                    hold_req = 1'b1;
                end
                3: begin
                    // a zero limit turns every header away
                    cfg_set({$urandom, $urandom}, {$urandom, $urandom}, 17'd0);
                    src_idle_pct = 35; snk_stall_pct = 35;
                end
                4: begin
                    cfg_set({$urandom, $urandom}, {$urandom, $urandom}, 17'(MAX_RECORD_BYTES));
                    src_idle_pct = 35; snk_stall_pct = 35;
                end
                default: begin
                    cfg_set({$urandom, $urandom}, {$urandom, $urandom},
                            17'($urandom_range(MAX_RECORD_BYTES, 1)));
                    src_idle_pct = 0;  snk_stall_pct = 0;
                end
            endcase

            if (ph == 4)
            begin
                // full-size two-fragment record, tail first, completes on the big one
                frag = random_item();
                frag.scene_identity = want_world;
                frag.asset_identity = want_asset;
                frag.transfer_tag[0] = 1'b1;
                frag.fragment_total = 7'd2;
                rec = FRAGMENT_BYTES + $urandom_range(6, 1);
                frag.record_bytes = 17'(rec);
                frag.fragment_number = 7'd1;
                frag.payload_size = 11'(rec - FRAGMENT_BYTES);
                send_fragment(frag, 1'b0);
                frag.fragment_number = 7'd0;
                frag.payload_size = 11'(FRAGMENT_BYTES);
                send_fragment(frag, 1'b0);
            end

            goal = items_sent + ((ph == 3) ? 30 : 50);
            while (items_sent < goal)
            begin
                if ($urandom_range(4) == 0)
                begin
                    // noise fragment
                    frag = random_item();
                    if ($urandom_range(1))
                    begin
                        frag.scene_identity = want_world;
                        frag.asset_identity = want_asset;
                    end
                    frag.payload_size = 11'($urandom_range(4));
                    send_fragment(frag, 1'b0);
                end
                else
                    gen_transfer();
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ snapshot_fragment_reassembly.f @@
design/sfr_pkg.sv
design/sfr_if.sv
design/sfr_front.sv
design/sfr_queue.sv
design/sfr_back.sv
design/snapshot_fragment_reassembly.sv
sim/tb_snapshot_fragment_reassembly.sv
